FILE: sv/kpeq_pkg.sv
// shared types, constants and helpers of the key press event queue
package kpeq_pkg;

  localparam int unsigned KEY_COUNT        = 4;
  localparam int unsigned QUEUE_LAST_INDEX = 15;
  localparam int unsigned PTR_W            = $clog2(QUEUE_LAST_INDEX + 1);
  localparam int unsigned KEY_IDX_W        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam logic [7:0] CODE_BASE = 8'd48;
  localparam logic [4:0] MAX_READ  = 5'd16;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    KIND_SCAN  = 2'd0,
    KIND_CODE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kpeq_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } kpeq_state_e;

  typedef struct packed {
    logic       command;
    logic [3:0] keys_pressed;
    logic [4:0] read_count;
  } kpeq_req_t;

  typedef struct packed {
    kpeq_kind_e kind;
    logic [7:0] key_code;
    logic [2:0] queued_count;
    logic       last;
  } kpeq_res_t;

  // scan token walking down the row of key cells
  typedef struct packed {
    logic                 valid;
    logic [KEY_COUNT-1:0] keys;
    logic [KEY_IDX_W-1:0] idx;
    logic [2:0]           count;
  } kpeq_tok_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_IDX_W-1:0] idx;
  } kpeq_push_t;

  typedef struct packed {
    logic                 valid;
    logic                 empty;
    logic                 last;
    logic [KEY_IDX_W-1:0] idx;
  } kpeq_pop_t;

  function automatic ptr_t next_slot(ptr_t p);
    ptr_t n;
    if (p == ptr_t'(QUEUE_LAST_INDEX)) begin
      n = '0;
    end else begin
      n = p + ptr_t'(1);
    end
    return n;
  endfunction

endpackage

FILE: sv/key_press_event_queue_unit.sv
// top level of the key press event queue: command control and result register
//
// usage: a request is taken at a rising edge with start high and busy low.
// req_i.command selects a scan (0) or a read (1). results appear on res_o
// for exactly one cycle each, marked by res_strobe_o; the receiver cannot
// stall them and must take every one.
// scan: the token walks the row of key cells, one key per cycle, pushing
// codes of newly pressed keys into the ring queue. one result of kind scan
// follows once the token has left the last cell and passed the result
// register; busy drops in the same cycle as that result appears.
// read: pops up to min(read_count, 16) codes, one per cycle; each code passes
// the store read register and the result register, and busy drops with the
// last one. an empty read gives one result of kind empty. the pace is set
// by the single read port of the code store.
// reset: all keys count as released, the queue is empty, no result pending.
// the store itself is not cleared; the pointers never reach an unwritten slot.
module key_press_event_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  kpeq_pkg::kpeq_req_t req_i,
  output logic                res_strobe_o,
  output kpeq_pkg::kpeq_res_t res_o
);
  import kpeq_pkg::*;

  kpeq_state_e state_q, state_d;
  logic        scan_go, read_go;

  kpeq_tok_t   tok0_q;
  kpeq_tok_t   tok  [KEY_COUNT+1];
  kpeq_push_t  cell_push [KEY_COUNT];
  kpeq_push_t  push;
  kpeq_pop_t   pop;
  ptr_t        wptr, rptr;

  kpeq_res_t   res_q, res_d;
  logic        strobe_q, strobe_d;
  logic        scan_done, read_done;

  assign tok[0] = tok0_q;

  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_cell
    kpeq_key_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .wptr_i (wptr),
      .rptr_i (rptr),
      .tok_o  (tok[g+1]),
      .push_o (cell_push[g])
    );
  end

  // only one cell holds the token at a time
  always_comb begin
    push = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (cell_push[i].valid) begin
        push = cell_push[i];
      end
    end
  end

  kpeq_code_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rd_start_i (read_go),
    .rd_want_i  (req_i.read_count),
    .wptr_o     (wptr),
    .rptr_o     (rptr),
    .pop_o      (pop)
  );

  assign scan_done = tok[KEY_COUNT].valid;
  assign read_done = (pop.valid && pop.last) || pop.empty;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = req_i.command ? ST_READ : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (read_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy    = (state_q != ST_IDLE);
    scan_go = (state_q == ST_IDLE) && start && !req_i.command;
    read_go = (state_q == ST_IDLE) && start && req_i.command;
  end

  // result register
  always_comb begin
    res_d    = '0;
    strobe_d = 1'b0;
    priority if (scan_done) begin
      strobe_d           = 1'b1;
      res_d.kind         = KIND_SCAN;
      res_d.queued_count = tok[KEY_COUNT].count;
      res_d.last         = 1'b1;
    end else if (pop.valid) begin
      strobe_d       = 1'b1;
      res_d.kind     = KIND_CODE;
      res_d.key_code = CODE_BASE + 8'(pop.idx);
      res_d.last     = pop.last;
    end else if (pop.empty) begin
      strobe_d   = 1'b1;
      res_d.kind = KIND_EMPTY;
      res_d.last = 1'b1;
    end else begin
      strobe_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tok0_q   <= '0;
      strobe_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q      <= state_d;
      tok0_q.valid <= scan_go;
      tok0_q.keys  <= req_i.keys_pressed[KEY_COUNT-1:0];
      tok0_q.idx   <= '0;
      tok0_q.count <= '0;
      strobe_q     <= strobe_d;
      res_q        <= res_d;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  a_scan_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !(pop.valid || pop.empty))
    else $error("queue output during a scan");

  a_read_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !push.valid)
    else $error("push during a read");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |-> !busy)
    else $error("final result while still busy");

endmodule

FILE: sv/kpeq_key_cell.sv
// one key cell: release tracking and push decision for one key
module kpeq_key_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kpeq_pkg::kpeq_tok_t  tok_i,
  input  kpeq_pkg::ptr_t       wptr_i,
  input  kpeq_pkg::ptr_t       rptr_i,
  output kpeq_pkg::kpeq_tok_t  tok_o,
  output kpeq_pkg::kpeq_push_t push_o
);
  import kpeq_pkg::*;

  logic      released_q, released_d;
  kpeq_tok_t tok_q, tok_d;
  logic      full;
  logic      pressed;

  always_comb begin
    pressed = tok_i.keys[0];
    // one slot always stays empty
    full    = (next_slot(wptr_i) == rptr_i);

    push_o.valid = tok_i.valid & pressed & released_q & ~full;
    push_o.idx   = tok_i.idx;

    released_d = tok_i.valid ? ~pressed : released_q;

    tok_d.valid = tok_i.valid;
    tok_d.keys  = tok_i.keys >> 1;
    tok_d.idx   = tok_i.idx + KEY_IDX_W'(1);
    tok_d.count = tok_i.count + 3'(push_o.valid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      released_q <= 1'b1;
      tok_q      <= '0;
    end else begin
      released_q <= released_d;
      tok_q      <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: sv/kpeq_code_queue.sv
// ring queue of key indices with pointers and the read sequencer
module kpeq_code_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kpeq_pkg::kpeq_push_t push_i,
  input  logic                 rd_start_i,
  input  logic [4:0]           rd_want_i,
  output kpeq_pkg::ptr_t       wptr_o,
  output kpeq_pkg::ptr_t       rptr_o,
  output kpeq_pkg::kpeq_pop_t  pop_o
);
  import kpeq_pkg::*;

  logic [KEY_IDX_W-1:0] store_q [QUEUE_LAST_INDEX+1];
  logic [KEY_IDX_W-1:0] rd_idx_q;

  ptr_t       wptr_q, rptr_q, rptr_nx;
  logic       active_q;
  logic [4:0] remain_q;
  logic       pop_valid_q, pop_empty_q, pop_last_q;
  logic       pop_go, pop_last_d;

  always_comb begin
    rptr_nx    = next_slot(rptr_q);
    pop_go     = active_q && (remain_q != 5'd0) && (rptr_q != wptr_q);
    pop_last_d = (remain_q == 5'd1) || (rptr_nx == wptr_q);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      store_q[wptr_q] <= push_i.idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_go) begin
      rd_idx_q <= store_q[rptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      active_q    <= 1'b0;
      remain_q    <= '0;
      pop_valid_q <= 1'b0;
      pop_empty_q <= 1'b0;
      pop_last_q  <= 1'b0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= next_slot(wptr_q);
      end
      pop_valid_q <= pop_go;
      pop_empty_q <= active_q & ~pop_go;
      pop_last_q  <= pop_go ? pop_last_d : 1'b1;
      if (rd_start_i) begin
        active_q <= 1'b1;
        remain_q <= (rd_want_i > MAX_READ) ? MAX_READ : rd_want_i;
      end else if (active_q) begin
        if (pop_go) begin
          rptr_q   <= rptr_nx;
          remain_q <= remain_q - 5'd1;
          if (pop_last_d) begin
            active_q <= 1'b0;
          end
        end else begin
          // nothing to give on the first step: empty result
          active_q <= 1'b0;
        end
      end
    end
  end

  assign wptr_o      = wptr_q;
  assign rptr_o      = rptr_q;
  assign pop_o.valid = pop_valid_q;
  assign pop_o.empty = pop_empty_q;
  assign pop_o.last  = pop_last_q;
  assign pop_o.idx   = rd_idx_q;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (next_slot(wptr_q) != rptr_q))
    else $error("push into a full queue");

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_go |-> !push_i.valid)
    else $error("push and pop in the same cycle");

  a_mid_pop_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_q && !pop_last_q) |-> active_q)
    else $error("read stopped before its last code");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_start_i |-> !active_q)
    else $error("read request while a read is running");

endmodule

FILE: sim/tb.sv
// testbench for the key press event queue: directed and random scans and reads
`timescale 1ns / 100ps

module tb;
  import kpeq_pkg::*;

  localparam logic        CMD_SCAN    = 1'b0;
  localparam logic        CMD_READ    = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 60000;
  localparam int unsigned SETTLE_CYC  = 20;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  kpeq_req_t req_i  = '0;
  logic      res_strobe_o;
  kpeq_res_t res_o;

  // model of the key latches and the ring queue
  logic [KEY_COUNT-1:0] released_keys = '1;
  logic [KEY_IDX_W-1:0] code_slots [QUEUE_LAST_INDEX+1];
  ptr_t                 wr_ptr = '0;
  ptr_t                 rd_ptr = '0;

  kpeq_res_t   expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned result_count   = 0;
  logic        idle_enable    = 1'b1;

  key_press_event_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", result_count, msg);
    mismatch_count++;
  endtask

  // works out the results that one request causes
  function automatic void predict_key_queue(input kpeq_req_t r);
    kpeq_res_t   res;
    ptr_t        wr_next;
    int unsigned want;
    int unsigned pops;
    logic [2:0]  pushed;
    res = '0;
    if (r.command == CMD_SCAN) begin
      pushed = '0;
      for (int k = 0; k < int'(KEY_COUNT); k++) begin
        if (r.keys_pressed[k]) begin
          if (released_keys[k]) begin
            wr_next = (wr_ptr == ptr_t'(QUEUE_LAST_INDEX)) ? '0 : wr_ptr + ptr_t'(1);
            // one slot stays empty, a push into a full queue is lost
            if (wr_next != rd_ptr) begin
              code_slots[wr_ptr] = KEY_IDX_W'(k);
              wr_ptr = wr_next;
              pushed++;
            end
          end
          released_keys[k] = 1'b0;
        end else begin
          released_keys[k] = 1'b1;
        end
      end
      res.kind         = KIND_SCAN;
      res.queued_count = pushed;
      res.last         = 1'b1;
      expected_results.push_back(res);
    end else begin
      want = (r.read_count > MAX_READ) ? MAX_READ : r.read_count;
      pops = 0;
      while (pops < want && rd_ptr != wr_ptr) begin
        res          = '0;
        res.kind     = KIND_CODE;
        res.key_code = CODE_BASE + 8'(code_slots[rd_ptr]);
        rd_ptr = (rd_ptr == ptr_t'(QUEUE_LAST_INDEX)) ? '0 : rd_ptr + ptr_t'(1);
        pops++;
        res.last = (pops == want) || (rd_ptr == wr_ptr);
        expected_results.push_back(res);
      end
      if (pops == 0) begin
        res      = '0;
        res.kind = KIND_EMPTY;
        res.last = 1'b1;
        expected_results.push_back(res);
      end
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    kpeq_res_t want_r;
    if (rst_ni && res_strobe_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res_o));
      end else begin
        want_r = expected_results.pop_front();
        if (res_o.kind !== want_r.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", res_o.kind, want_r.kind));
        if (res_o.key_code !== want_r.key_code)
          report_mismatch($sformatf("key_code %0d, expected %0d",
                                    res_o.key_code, want_r.key_code));
        if (res_o.queued_count !== want_r.queued_count)
          report_mismatch($sformatf("queued_count %0d, expected %0d",
                                    res_o.queued_count, want_r.queued_count));
        if (res_o.last !== want_r.last)
          report_mismatch($sformatf("last %0b, expected %0b", res_o.last, want_r.last));
      end
      result_count++;
    end
  end

  function automatic int unsigned pick_gap();
    if (!idle_enable || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 11);
  endfunction

  // start stays high after the handshake; the gap or the next request decides
  task automatic issue_request(input kpeq_req_t r);
    int unsigned gap;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_key_queue(r);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_scan(input logic [3:0] keys);
    kpeq_req_t r;
    r.command      = CMD_SCAN;
    r.keys_pressed = keys;
    r.read_count   = 5'($urandom_range(0, 31));
    issue_request(r);
  endtask

  task automatic send_read(input logic [4:0] count);
    kpeq_req_t r;
    r.command      = CMD_READ;
    r.keys_pressed = 4'($urandom_range(0, 15));
    r.read_count   = count;
    issue_request(r);
  endtask

  // called right after a handshake edge, so start gets one assignment here
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_press_edges();
    send_read(5'd3);
    send_scan(4'b1111);
    send_scan(4'b1111);
    send_scan(4'b0000);
  endtask

  task automatic test_full_queue();
    send_scan(4'b1111);
    send_scan(4'b0000);
    send_scan(4'b1111);
    send_scan(4'b0000);
    // last key is dropped here, queue holds fifteen codes
    send_scan(4'b1111);
    send_scan(4'b0111);
    // released key comes back while full: dropped but blocked afterwards
    send_scan(4'b1111);
  endtask

  task automatic test_read_limits();
    send_read(5'd0);
    send_read(5'd31);
    send_read(5'd5);
    send_scan(4'b0000);
    send_scan(4'b0101);
    send_read(5'd1);
    send_read(5'd16);
    send_scan(4'b1010);
    send_read(5'd17);
  endtask

  task automatic random_item();
    logic [4:0] count;
    if ($urandom_range(0, 9) < 6) begin
      send_scan(($urandom_range(0, 3) == 0) ? 4'b0000 : 4'($urandom_range(0, 15)));
    end else begin
      case ($urandom_range(0, 9))
        0:       count = 5'($urandom_range(16, 31));
        1, 2:    count = 5'($urandom_range(7, 15));
        default: count = 5'($urandom_range(0, 6));
      endcase
      send_read(count);
    end
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 65; n++) begin
      idle_enable = !(n >= 20 && n < 34);
      random_item();
      if (n == 45) wait_drained();
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_steady_stream();
    idle_enable = 1'b0;
    for (int n = 0; n < 25; n++) random_item();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_press_edges();
    test_full_queue();
    test_read_limits();
    test_random_traffic();
    test_steady_stream();
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
